[hw/rtl/assert_macros.svh]
// Assertion macros shared by the RTL of the packet deframer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of clk_i, switched off while rst_ni is low.
`define PDC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising edge of clk_i, reset included.
`define PDC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[hw/rtl/pdc_pkg.sv]
// Types, codes and the CRC-16 step function of the packet deframer.
package pdc_pkg;

  // Default largest payload length in bytes.
  localparam int unsigned MAX_PAYLOAD_DEF = 32;

  // Width of the configuration register index.
  localparam int unsigned CFG_IDX_W = 8;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_DATA_TAG      = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACK_TAG       = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INVALID_ID    = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS = 8'd3;

  // Register values after reset.
  localparam logic [7:0]  DATA_TAG_RST      = 8'd165;
  localparam logic [7:0]  ACK_TAG_RST       = 8'd90;
  localparam logic [7:0]  INVALID_ID_RST    = 8'hFF;
  localparam logic [15:0] TIMEOUT_TICKS_RST = 16'd1000;

  // CRC-16/CCITT constants.
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  // Input operation codes.
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Result kinds.
  localparam logic [1:0] KIND_PAYLOAD  = 2'd0;
  localparam logic [1:0] KIND_SEND_ACK = 2'd1;
  localparam logic [1:0] KIND_PEER_ACK = 2'd2;
  localparam logic [1:0] KIND_ERROR    = 2'd3;

  // Error codes.
  localparam logic [2:0] ERR_NONE       = 3'd0;
  localparam logic [2:0] ERR_DATA_CRC   = 3'd1;
  localparam logic [2:0] ERR_ACK_CRC    = 3'd2;
  localparam logic [2:0] ERR_LENGTH     = 3'd3;
  localparam logic [2:0] ERR_INVALID_ID = 3'd4;
  localparam logic [2:0] ERR_SEQUENCE   = 3'd5;
  localparam logic [2:0] ERR_NO_ROOM    = 3'd6;
  localparam logic [2:0] ERR_TIMEOUT    = 3'd7;

  // One input beat.
  typedef struct packed {
    logic        op;
    logic [7:0]  rx_byte;
    logic [15:0] sink_free;
  } pdc_in_t;

  // One result beat.
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] value;
    logic [2:0] error_code;
    logic       last;
  } pdc_out_t;

  // Folds one byte into the CRC, most significant bit first.
  function automatic logic [15:0] crc16_update(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
    logic [15:0] crc;
    crc = crc_in ^ {data, 8'h00};
    for (int b = 0; b < 8; b++) begin
      if (crc[15]) begin
        crc = {crc[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        crc = {crc[14:0], 1'b0};
      end
    end
    return crc;
  endfunction

endpackage

[hw/rtl/packet_deframer_crc_sequence_ack_top.sv]
// Stop-and-wait receiver: packet deframing, CRC-16 check, sequence rule and ack requests.
//
// Input channel (in_valid_i, in_ready_o, in_data_i): each beat is either one
// received link byte or one timer tick, with the free room of the sink.
// Output channel (out_valid_o, out_ready_i, out_data_o): payload bytes, ack
// requests, received peer acks and error reports; last marks the final result
// caused by one input beat. Configuration channel (cfg_valid_i, cfg_index_i,
// cfg_data_i) is always ready and writes the tags, the invalid id and the
// timeout; it is meant to be written between packets while no result is due.
// The result of an input beat, if any, sits in the output register from the
// next cycle on. A good data packet's payload bytes are released from the
// packet store through its registered read port, each byte passing the states
// S_RD and S_OUT in turn, followed by its ack request from S_ACK; no input is
// taken while this goes on. The output register takes a new result in the
// cycle the old one is taken, so a stalled receiver holds its result and
// blocks further input.
// Reset returns the block to hunting for a tag, restores the register values
// and clears the last accepted id to the invalid id; the packet store is not
// cleared, it is only read where it has been written.
module packet_deframer_crc_sequence_ack_top
  import pdc_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  pdc_in_t              in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output pdc_out_t             out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [15:0]          cfg_data_i
);

`include "assert_macros.svh"

  localparam int unsigned STORE_LEN = MAX_PAYLOAD + 5;
  localparam int unsigned CNT_W     = $clog2(STORE_LEN + 1);
  localparam int unsigned ADDR_W    = $clog2(STORE_LEN);
  localparam int unsigned POS_W     = 9;

  // Sequencer states.
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_OUT  = 2'd2;
  localparam logic [1:0] S_ACK  = 2'd3;

  // Configuration registers.
  logic [7:0]  data_tag_q, ack_tag_q, invalid_id_q;
  logic [15:0] timeout_q;

  // Control state.
  logic [1:0]       st_q, st_d;
  logic             recv_q, recv_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [15:0]      ticks_q, ticks_d;
  logic [7:0]       last_id_q, last_id_d;
  logic             out_valid_q, out_valid_d;

  // Packet fields captured on the fly.
  logic [7:0]       tag_q, tag_d;
  logic [7:0]       id_q, id_d;
  logic [7:0]       len_q, len_d;
  logic [7:0]       b3_q, b3_d;
  logic [7:0]       crclo_q, crclo_d;
  logic [15:0]      crc_run_q, crc_run_d;
  logic [15:0]      crc_ack_q, crc_ack_d;
  logic [CNT_W-1:0] rd_ptr_q, rd_ptr_d;
  pdc_out_t         out_q, out_d;

  // Packet store.
  logic [7:0]       store_mem [STORE_LEN];
  logic [7:0]       mem_rd_q;
  logic             mem_we;
  logic [ADDR_W-1:0] mem_wa;

  logic             in_fire, cfg_fire, out_free, out_load;
  logic [7:0]       c;
  logic [15:0]      crc_in, crc_next, tick_sat;
  logic [POS_W-1:0] pos, len9;
  logic [CNT_W-1:0] rd_end, rd_ptr_inc;
  logic [7:0]       expect_id, b3_cur;
  logic             seq_bad;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (st_q == S_IDLE) && out_free;
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign c          = in_data_i.rx_byte;
  assign pos        = POS_W'(cnt_q);
  assign len9       = {1'b0, len_q};
  assign crc_in     = recv_q ? crc_run_q : CRC_INIT;
  assign crc_next   = crc16_update(crc_in, c);
  assign tick_sat   = (ticks_q == 16'hFFFF) ? ticks_q : ticks_q + 16'd1;
  assign rd_end     = CNT_W'(len9 + POS_W'(3));
  assign rd_ptr_inc = rd_ptr_q + CNT_W'(1);
  assign b3_cur     = (pos == POS_W'(3)) ? c : b3_q;

  // Sequence rule: next id after the last accepted one, skipping the invalid id.
  always_comb begin
    expect_id = last_id_q + 8'd1;
    if (expect_id == invalid_id_q) begin
      expect_id = 8'd1;
    end
    seq_bad = (last_id_q != invalid_id_q) && (id_q != 8'd0) && (id_q != expect_id);
  end

  // Deframing, packet checks and payload release.
  always_comb begin
    st_d        = st_q;
    recv_d      = recv_q;
    cnt_d       = cnt_q;
    ticks_d     = ticks_q;
    last_id_d   = last_id_q;
    tag_d       = tag_q;
    id_d        = id_q;
    len_d       = len_q;
    b3_d        = b3_q;
    crclo_d     = crclo_q;
    crc_run_d   = crc_run_q;
    crc_ack_d   = crc_ack_q;
    rd_ptr_d    = rd_ptr_q;
    out_load    = 1'b0;
    out_d       = '{kind: KIND_ERROR, value: 8'd0, error_code: ERR_NONE, last: 1'b1};
    mem_we      = 1'b0;
    mem_wa      = cnt_q[ADDR_W-1:0];

    unique case (st_q)
      S_IDLE: begin
        if (in_fire) begin
          if (in_data_i.op == OP_TICK) begin
            // Timer tick: only counts while a packet is under way.
            if (recv_q) begin
              ticks_d = tick_sat;
              if (tick_sat > timeout_q) begin
                recv_d           = 1'b0;
                out_load         = 1'b1;
                out_d.error_code = ERR_TIMEOUT;
              end
            end
          end else if (!recv_q) begin
            // Hunt for a tag.
            if (c == data_tag_q || c == ack_tag_q) begin
              recv_d    = 1'b1;
              ticks_d   = 16'd0;
              mem_we    = 1'b1;
              mem_wa    = '0;
              tag_d     = c;
              cnt_d     = CNT_W'(1);
              crc_run_d = crc_next;
            end
          end else if (cnt_q >= CNT_W'(STORE_LEN)) begin
            recv_d = 1'b0;
          end else begin
            mem_we = 1'b1;
            cnt_d  = cnt_q + CNT_W'(1);
            if (pos == POS_W'(1)) begin
              id_d      = c;
              crc_ack_d = crc_next;
            end
            if (pos == POS_W'(2)) begin
              len_d = c;
            end
            if (pos == POS_W'(3)) begin
              b3_d = c;
            end
            if (pos < POS_W'(3) || pos < len9 + POS_W'(3)) begin
              crc_run_d = crc_next;
            end
            if (pos == len9 + POS_W'(3)) begin
              crclo_d = c;
            end

            if (tag_q == data_tag_q) begin
              if (pos >= POS_W'(3)) begin
                if (len_q > 8'(MAX_PAYLOAD)) begin
                  recv_d           = 1'b0;
                  out_load         = 1'b1;
                  out_d.error_code = ERR_LENGTH;
                end else if (pos == len9 + POS_W'(4)) begin
                  recv_d = 1'b0;
                  if (crclo_q != crc_run_q[7:0] || c != crc_run_q[15:8]) begin
                    out_load         = 1'b1;
                    out_d.error_code = ERR_DATA_CRC;
                  end else if (id_q == invalid_id_q) begin
                    out_load         = 1'b1;
                    out_d.error_code = ERR_INVALID_ID;
                  end else if (id_q == last_id_q) begin
                    // Duplicate: acknowledge again, drop the payload.
                    out_load   = 1'b1;
                    out_d.kind = KIND_SEND_ACK;
                    out_d.value = id_q;
                  end else if (seq_bad) begin
                    out_load         = 1'b1;
                    out_d.error_code = ERR_SEQUENCE;
                  end else if ({8'd0, len_q} > in_data_i.sink_free) begin
                    out_load         = 1'b1;
                    out_d.error_code = ERR_NO_ROOM;
                  end else begin
                    last_id_d = id_q;
                    if (len_q == 8'd0) begin
                      out_load    = 1'b1;
                      out_d.kind  = KIND_SEND_ACK;
                      out_d.value = id_q;
                    end else begin
                      st_d     = S_RD;
                      rd_ptr_d = CNT_W'(3);
                    end
                  end
                end
              end
            end else if (tag_q == ack_tag_q) begin
              if (pos >= POS_W'(3)) begin
                recv_d   = 1'b0;
                out_load = 1'b1;
                if (len_q != crc_ack_q[7:0] || b3_cur != crc_ack_q[15:8]) begin
                  out_d.error_code = ERR_ACK_CRC;
                end else begin
                  out_d.kind  = KIND_PEER_ACK;
                  out_d.value = id_q;
                end
              end
            end else begin
              // The stored tag no longer matches either tag: drop silently.
              recv_d = 1'b0;
            end
          end
        end
      end
      S_RD: begin
        st_d = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          out_load    = 1'b1;
          out_d.kind  = KIND_PAYLOAD;
          out_d.value = mem_rd_q;
          out_d.last  = 1'b0;
          rd_ptr_d    = rd_ptr_inc;
          st_d        = (rd_ptr_inc == rd_end) ? S_ACK : S_RD;
        end
      end
      S_ACK: begin
        if (out_free) begin
          out_load    = 1'b1;
          out_d.kind  = KIND_SEND_ACK;
          out_d.value = id_q;
          st_d        = S_IDLE;
        end
      end
      default: begin
        st_d = S_IDLE;
      end
    endcase

    out_valid_d = out_load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  end

  // Control registers and configuration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q         <= S_IDLE;
      recv_q       <= 1'b0;
      cnt_q        <= '0;
      ticks_q      <= 16'd0;
      last_id_q    <= INVALID_ID_RST;
      out_valid_q  <= 1'b0;
      data_tag_q   <= DATA_TAG_RST;
      ack_tag_q    <= ACK_TAG_RST;
      invalid_id_q <= INVALID_ID_RST;
      timeout_q    <= TIMEOUT_TICKS_RST;
    end else begin
      st_q        <= st_d;
      recv_q      <= recv_d;
      cnt_q       <= cnt_d;
      ticks_q     <= ticks_d;
      last_id_q   <= last_id_d;
      out_valid_q <= out_valid_d;
      if (cfg_fire) begin
        unique case (cfg_index_i)
          CFG_DATA_TAG:      data_tag_q   <= cfg_data_i[7:0];
          CFG_ACK_TAG:       ack_tag_q    <= cfg_data_i[7:0];
          CFG_INVALID_ID:    invalid_id_q <= cfg_data_i[7:0];
          CFG_TIMEOUT_TICKS: timeout_q    <= cfg_data_i;
          default: begin
          end
        endcase
      end
    end
  end

  // Captured packet fields and the output register.
  always_ff @(posedge clk_i) begin
    tag_q     <= tag_d;
    id_q      <= id_d;
    len_q     <= len_d;
    b3_q      <= b3_d;
    crclo_q   <= crclo_d;
    crc_run_q <= crc_run_d;
    crc_ack_q <= crc_ack_d;
    rd_ptr_q  <= rd_ptr_d;
    if (out_load) begin
      out_q <= out_d;
    end
  end

  // Packet store: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      store_mem[mem_wa] <= c;
    end
    mem_rd_q <= store_mem[rd_ptr_q[ADDR_W-1:0]];
  end

  // Assertions.
  `PDC_ASSERT(a_burst_ptr_range,
    (st_q == S_OUT) |-> (rd_ptr_q >= CNT_W'(3) && rd_ptr_q < rd_end),
    "payload read pointer outside the stored payload")
  `PDC_ASSERT(a_payload_not_last,
    (out_valid_o && out_data_o.kind == KIND_PAYLOAD) |-> !out_data_o.last,
    "payload beat marked as last result")
  `PDC_ASSERT(a_error_code_only_on_error,
    (out_valid_o && out_data_o.kind != KIND_ERROR) |-> (out_data_o.error_code == ERR_NONE),
    "error code set on a result that is not an error")
  `PDC_ASSERT_ALWAYS(a_reset_clears_output,
    !rst_ni |=> !out_valid_o,
    "result valid straight after reset")

endmodule
